// ===== sv/free_list_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// free_list_allocator_core_assert.svh
// Assertion macros for the free list allocator; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FLA_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// next-cycle implication
`define FLA_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`else

`define FLA_ASSERT_IMPLY(label, clk, rst, a, b)
`define FLA_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

// ===== sv/fla_pkg.sv =====
// ----------------------------------------------------------------------------
// fla_pkg
// Shared constants and types of the free list allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

   localparam int UNIT_BYTES  = 16;
   localparam int UNIT_SHIFT  = 4;
   localparam logic [11:0] CHUNK_RESET = 12'd1024;

   localparam logic [1:0] KIND_ALLOC  = 2'd0;
   localparam logic [1:0] KIND_CALLOC = 2'd1;
   localparam logic [1:0] KIND_FREE   = 2'd2;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_OOM  = 1'b1;

   // per-field write enables of the header store
   typedef struct packed {
      logic next_we;
      logic size_we;
   } hdr_we_type;

endpackage

// ===== sv/fla_hdr_ram.sv =====
// ----------------------------------------------------------------------------
// fla_hdr_ram
// Header store: link and size fields, one port, registered read data.
// ----------------------------------------------------------------------------
module fla_hdr_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                   clock,
   input  logic [AW-1:0]          addr,
   input  fla_pkg::hdr_we_type    we,
   input  logic [AW-1:0]          wr_next,
   input  logic [AW:0]            wr_size,
   output logic [AW-1:0]          rd_next,
   output logic [AW:0]            rd_size
);

   logic [AW-1:0] next_mem [DEPTH];
   logic [AW:0]   size_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we.next_we) begin
         next_mem[addr] <= wr_next;
      end
      if (we.size_we) begin
         size_mem[addr] <= wr_size;
      end
      rd_next <= next_mem[addr];
      rd_size <= size_mem[addr];
   end

endmodule

// ===== sv/free_list_allocator_core.sv =====
// ----------------------------------------------------------------------------
// free_list_allocator_core
// First-fit heap allocator with an address-ordered circular free list.
// ----------------------------------------------------------------------------
// One request at a time: busy stays high from start until the single result
// word is strobed on rsp_valid for one cycle; the receiver cannot stall, so
// the result must be captured then. Latency is set by the walk over the
// header store, one port with registered reads: setup, then a walk over the
// free-list nodes by an allocation, or a walk by a free (or by the free that
// a heap growth performs) followed by merging and wrap-up. No clearing pass
// after reset.
// ----------------------------------------------------------------------------
`include "free_list_allocator_core_assert.svh"

module free_list_allocator_core #(
   parameter int ARENA_UNITS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [19:0] req_byte_count,
   input  logic [15:0] req_elem_count,
   input  logic [15:0] req_elem_size,
   input  logic [11:0] req_block_addr,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic [11:0] rsp_payload_unit,
   output logic [11:0] rsp_granted_units,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_wdata
);

   localparam int AW  = $clog2(ARENA_UNITS);
   localparam int XW  = (AW + 2 > 13) ? AW + 2 : 13;
   localparam int STW = AW + 3;
   localparam logic [AW:0]    ARENA_L   = (AW+1)'(ARENA_UNITS);
   localparam logic [XW:0]    ARENA_X   = (XW+1)'(ARENA_UNITS);
   localparam logic [XW-1:0]  NEED_SAT  = XW'(ARENA_UNITS + 1);
   localparam logic [STW-1:0] WALK_LIM  = STW'(2 * ARENA_UNITS + 8);

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_INIT    = 5'd1;
   localparam logic [4:0] ST_NEED    = 5'd2;
   localparam logic [4:0] ST_A_FIRST = 5'd3;
   localparam logic [4:0] ST_A_GETP  = 5'd4;
   localparam logic [4:0] ST_A_CHK   = 5'd5;
   localparam logic [4:0] ST_A_SPLIT = 5'd6;
   localparam logic [4:0] ST_A_ADV   = 5'd7;
   localparam logic [4:0] ST_GROW    = 5'd8;
   localparam logic [4:0] ST_R_START = 5'd9;
   localparam logic [4:0] ST_R_LOOP  = 5'd10;
   localparam logic [4:0] ST_R_RDBP  = 5'd11;
   localparam logic [4:0] ST_R_RDNX  = 5'd12;
   localparam logic [4:0] ST_R_M1    = 5'd13;
   localparam logic [4:0] ST_R_M2    = 5'd14;
   localparam logic [4:0] ST_R_DONE  = 5'd15;

   // p + size stays below twice the arena on a sane list
   function automatic logic [AW-1:0] wrap_unit(input logic [AW+1:0] x);
      logic [AW+1:0] r;
      r = (x >= (AW+2)'(ARENA_UNITS)) ? x - (AW+2)'(ARENA_UNITS) : x;
      return r[AW-1:0];
   endfunction

   logic [4:0]     state_ff, state_in;
   logic [1:0]     kind_ff, kind_in;
   logic [19:0]    bcount_ff, bcount_in;
   logic [15:0]    ecount_ff, ecount_in;
   logic [15:0]    esize_ff, esize_in;
   logic [11:0]    baddr_ff, baddr_in;
   logic [31:0]    bytes_ff, bytes_in;
   logic [XW-1:0]  need_ff, need_in;
   logic [XW-1:0]  nu_ff, nu_in;
   logic [AW-1:0]  rover_ff, rover_in;
   logic           started_ff, started_in;
   logic [AW:0]    brk_ff, brk_in;
   logic [11:0]    chunk_ff, chunk_in;
   logic [AW-1:0]  p_ff, p_in;
   logic [AW-1:0]  prev_ff, prev_in;
   logic [AW-1:0]  nx_ff, nx_in;
   logic [AW-1:0]  bp_ff, bp_in;
   logic [AW:0]    psize_ff, psize_in;
   logic [AW:0]    bsize_ff, bsize_in;
   logic [AW-1:0]  bnext_ff, bnext_in;
   logic [STW-1:0] asteps_ff, asteps_in;
   logic [STW-1:0] rsteps_ff, rsteps_in;
   logic           grow_ff, grow_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_status_ff, rsp_status_in;
   logic [11:0]    rsp_unit_ff, rsp_unit_in;
   logic [11:0]    rsp_units_ff, rsp_units_in;

   logic [AW-1:0]       mem_addr;
   fla_pkg::hdr_we_type mem_we;
   logic [AW-1:0]       mem_wr_next;
   logic [AW:0]         mem_wr_size;
   logic [AW-1:0]       mem_rd_next;
   logic [AW:0]         mem_rd_size;

   logic [32:0]    round_sum;
   logic [28:0]    need_raw;
   logic [XW-1:0]  nu_pick;
   logic [XW:0]    brk_sum;
   logic [AW:0]    remain;
   logic [STW-1:0] asteps_inc;
   logic [STW-1:0] rsteps_inc;
   logic           addr_ok;
   logic           ins_here;

   fla_hdr_ram #(
      .DEPTH (ARENA_UNITS),
      .AW    (AW)
   ) u_hdr (
      .clock   (clock),
      .addr    (mem_addr),
      .we      (mem_we),
      .wr_next (mem_wr_next),
      .wr_size (mem_wr_size),
      .rd_next (mem_rd_next),
      .rd_size (mem_rd_size)
   );

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_payload_unit  = rsp_unit_ff;
   assign rsp_granted_units = rsp_units_ff;

   always_comb begin
      round_sum  = {1'b0, bytes_ff} + 33'(fla_pkg::UNIT_BYTES - 1);
      need_raw   = 29'(round_sum >> fla_pkg::UNIT_SHIFT) + 29'd1;
      nu_pick    = (need_ff < XW'(chunk_ff)) ? XW'(chunk_ff) : need_ff;
      brk_sum    = (XW+1)'(brk_ff) + (XW+1)'(nu_pick);
      remain     = mem_rd_size - (AW+1)'(need_ff);
      asteps_inc = asteps_ff + STW'(1);
      rsteps_inc = rsteps_ff + STW'(1);
      addr_ok    = (baddr_ff != 12'd0) &&
                   (32'(baddr_ff) - 32'd1 < 32'(ARENA_UNITS));
      ins_here   = ((bp_ff > p_ff) && (bp_ff < mem_rd_next)) ||
                   ((p_ff >= mem_rd_next) && ((bp_ff > p_ff) || (bp_ff < mem_rd_next)));
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      bcount_in     = bcount_ff;
      ecount_in     = ecount_ff;
      esize_in      = esize_ff;
      baddr_in      = baddr_ff;
      bytes_in      = bytes_ff;
      need_in       = need_ff;
      nu_in         = nu_ff;
      rover_in      = rover_ff;
      started_in    = started_ff;
      brk_in        = brk_ff;
      chunk_in      = chunk_ff;
      p_in          = p_ff;
      prev_in       = prev_ff;
      nx_in         = nx_ff;
      bp_in         = bp_ff;
      psize_in      = psize_ff;
      bsize_in      = bsize_ff;
      bnext_in      = bnext_ff;
      asteps_in     = asteps_ff;
      rsteps_in     = rsteps_ff;
      grow_in       = grow_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_unit_in   = rsp_unit_ff;
      rsp_units_in  = rsp_units_ff;
      mem_addr      = p_ff;
      mem_we        = '0;
      mem_wr_next   = '0;
      mem_wr_size   = '0;

      if (csr_valid && csr_ready) begin
         chunk_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in   = req_kind;
               bcount_in = req_byte_count;
               ecount_in = req_elem_count;
               esize_in  = req_elem_size;
               baddr_in  = req_block_addr;
               state_in  = ST_INIT;
            end
         end
         ST_INIT: begin
            // sentinel list set up by the first request of any kind
            if (!started_ff) begin
               mem_addr    = '0;
               mem_we      = '{next_we: 1'b1, size_we: 1'b1};
               rover_in    = '0;
               started_in  = 1'b1;
            end
            bytes_in = (kind_ff == fla_pkg::KIND_ALLOC) ? 32'(bcount_ff)
                                                        : 32'(ecount_ff) * 32'(esize_ff);
            priority if ((kind_ff == fla_pkg::KIND_ALLOC) ||
                         (kind_ff == fla_pkg::KIND_CALLOC)) begin
               state_in = ST_NEED;
            end else if (kind_ff == fla_pkg::KIND_FREE && addr_ok) begin
               bp_in    = AW'(baddr_ff - 12'd1);
               grow_in  = 1'b0;
               state_in = ST_R_START;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = fla_pkg::STATUS_DONE;
               rsp_unit_in   = '0;
               rsp_units_in  = '0;
               state_in      = ST_IDLE;
            end
         end
         ST_NEED: begin
            // anything above the arena can never fit; clamp keeps it failing
            need_in   = (need_raw > 29'(NEED_SAT)) ? NEED_SAT : XW'(need_raw);
            asteps_in = '0;
            state_in  = ST_A_FIRST;
         end
         ST_A_FIRST: begin
            prev_in  = rover_ff;
            mem_addr = rover_ff;
            state_in = ST_A_GETP;
         end
         ST_A_GETP: begin
            p_in     = mem_rd_next;
            mem_addr = mem_rd_next;
            state_in = ST_A_CHK;
         end
         ST_A_CHK: begin
            priority if ((XW+1)'(mem_rd_size) == (XW+1)'(need_ff)) begin
               mem_addr      = prev_ff;
               mem_we        = '{next_we: 1'b1, size_we: 1'b0};
               mem_wr_next   = mem_rd_next;
               rover_in      = prev_ff;
               rsp_valid_in  = 1'b1;
               rsp_status_in = fla_pkg::STATUS_DONE;
               rsp_unit_in   = 12'(wrap_unit((AW+2)'(p_ff) + (AW+2)'(1)));
               rsp_units_in  = 12'(need_ff);
               state_in      = ST_IDLE;
            end else if ((XW+1)'(mem_rd_size) > (XW+1)'(need_ff)) begin
               // split: keep the bottom, grant the top
               mem_addr    = p_ff;
               mem_we      = '{next_we: 1'b0, size_we: 1'b1};
               mem_wr_size = remain;
               p_in        = wrap_unit((AW+2)'(p_ff) + (AW+2)'(remain));
               state_in    = ST_A_SPLIT;
            end else if (p_ff == rover_ff) begin
               state_in = ST_GROW;
            end else begin
               state_in = ST_A_ADV;
            end
         end
         ST_A_SPLIT: begin
            mem_addr      = p_ff;
            mem_we        = '{next_we: 1'b0, size_we: 1'b1};
            mem_wr_size   = (AW+1)'(need_ff);
            rover_in      = prev_ff;
            rsp_valid_in  = 1'b1;
            rsp_status_in = fla_pkg::STATUS_DONE;
            rsp_unit_in   = 12'(wrap_unit((AW+2)'(p_ff) + (AW+2)'(1)));
            rsp_units_in  = 12'(need_ff);
            state_in      = ST_IDLE;
         end
         ST_A_ADV: begin
            asteps_in = asteps_inc;
            if (asteps_inc > WALK_LIM) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = fla_pkg::STATUS_OOM;
               rsp_unit_in   = '0;
               rsp_units_in  = '0;
               state_in      = ST_IDLE;
            end else begin
               prev_in  = p_ff;
               mem_addr = p_ff;
               state_in = ST_A_GETP;
            end
         end
         ST_GROW: begin
            if (brk_sum > ARENA_X) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = fla_pkg::STATUS_OOM;
               rsp_unit_in   = '0;
               rsp_units_in  = '0;
               state_in      = ST_IDLE;
            end else begin
               mem_addr    = AW'(brk_ff);
               mem_we      = '{next_we: 1'b0, size_we: 1'b1};
               mem_wr_size = (AW+1)'(nu_pick);
               nu_in       = nu_pick;
               bp_in       = AW'(brk_ff);
               grow_in     = 1'b1;
               state_in    = ST_R_START;
            end
         end
         ST_R_START: begin
            p_in      = rover_ff;
            mem_addr  = rover_ff;
            rsteps_in = '0;
            state_in  = ST_R_LOOP;
         end
         ST_R_LOOP: begin
            // read data holds header of p_ff
            if (ins_here) begin
               nx_in    = mem_rd_next;
               psize_in = mem_rd_size;
               state_in = ST_R_RDBP;
            end else if (rsteps_inc > WALK_LIM) begin
               state_in = ST_R_DONE;
            end else begin
               rsteps_in = rsteps_inc;
               p_in      = mem_rd_next;
               mem_addr  = mem_rd_next;
            end
         end
         ST_R_RDBP: begin
            mem_addr = bp_ff;
            state_in = ST_R_RDNX;
         end
         ST_R_RDNX: begin
            bsize_in = mem_rd_size;
            mem_addr = nx_ff;
            state_in = ST_R_M1;
         end
         ST_R_M1: begin
            // merge with the upper neighbor
            mem_addr = bp_ff;
            mem_we   = '{next_we: 1'b1, size_we: 1'b1};
            if ((AW+2)'(bp_ff) + (AW+2)'(bsize_ff) == (AW+2)'(nx_ff)) begin
               mem_wr_size = bsize_ff + mem_rd_size;
               mem_wr_next = mem_rd_next;
            end else begin
               mem_wr_size = bsize_ff;
               mem_wr_next = nx_ff;
            end
            bsize_in = mem_wr_size;
            bnext_in = mem_wr_next;
            state_in = ST_R_M2;
         end
         ST_R_M2: begin
            // merge with the lower neighbor
            mem_addr = p_ff;
            if ((AW+2)'(p_ff) + (AW+2)'(psize_ff) == (AW+2)'(bp_ff)) begin
               mem_we      = '{next_we: 1'b1, size_we: 1'b1};
               mem_wr_size = psize_ff + bsize_ff;
               mem_wr_next = bnext_ff;
            end else begin
               mem_we      = '{next_we: 1'b1, size_we: 1'b0};
               mem_wr_next = bp_ff;
            end
            rover_in = p_ff;
            state_in = ST_R_DONE;
         end
         ST_R_DONE: begin
            if (grow_ff) begin
               brk_in   = (AW+1)'(brk_ff + (AW+1)'(nu_ff));
               p_in     = rover_ff;
               state_in = ST_A_ADV;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = fla_pkg::STATUS_DONE;
               rsp_unit_in   = '0;
               rsp_units_in  = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rover_ff     <= '0;
         started_ff   <= 1'b0;
         brk_ff       <= (AW+1)'(1);
         chunk_ff     <= fla_pkg::CHUNK_RESET;
         grow_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rover_ff     <= rover_in;
         started_ff   <= started_in;
         brk_ff       <= brk_in;
         chunk_ff     <= chunk_in;
         grow_ff      <= grow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      bcount_ff     <= bcount_in;
      ecount_ff     <= ecount_in;
      esize_ff      <= esize_in;
      baddr_ff      <= baddr_in;
      bytes_ff      <= bytes_in;
      need_ff       <= need_in;
      nu_ff         <= nu_in;
      p_ff          <= p_in;
      prev_ff       <= prev_in;
      nx_ff         <= nx_in;
      bp_ff         <= bp_in;
      psize_ff      <= psize_in;
      bsize_ff      <= bsize_in;
      bnext_ff      <= bnext_in;
      asteps_ff     <= asteps_in;
      rsteps_ff     <= rsteps_in;
      rsp_status_ff <= rsp_status_in;
      rsp_unit_ff   <= rsp_unit_in;
      rsp_units_ff  <= rsp_units_in;
   end

   `FLA_ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `FLA_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `FLA_ASSERT_IMPLY(a_oom_zero, clock, reset, rsp_valid && rsp_status,
      rsp_payload_unit == 12'd0 && rsp_granted_units == 12'd0)
   `FLA_ASSERT_NEXT(a_started_sticks, clock, reset, started_ff, started_ff)
   `FLA_ASSERT_IMPLY(a_brk_bound, clock, reset, 1'b1, brk_ff <= ARENA_L)

endmodule
